### hw/rtl/kmq_pkg.sv
`default_nettype none

package kmq_pkg;

  // Queue geometry
  localparam int DEPTH       = 16;
  localparam int HANDLE_BITS = 16;
  localparam int KEY_W       = 32;
  localparam int OCC_W       = 5;
  localparam int IDX_W       = $clog2(DEPTH);
  localparam int CNT_W       = $clog2(DEPTH + 1);

  // Operation codes
  localparam logic [2:0] OP_PUSH_TAIL = 3'd0;
  localparam logic [2:0] OP_PUSH_HEAD = 3'd1;
  localparam logic [2:0] OP_POP_HEAD  = 3'd2;
  localparam logic [2:0] OP_REMOVE    = 3'd3;
  localparam logic [2:0] OP_FIND      = 3'd4;

  // Result status codes
  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_MISS = 2'd1;
  localparam logic [1:0] STAT_FULL = 2'd2;

  typedef struct packed {
    logic [2:0]             opcode;
    logic [KEY_W-1:0]       search_key;
    logic [HANDLE_BITS-1:0] record_handle;
  } req_t;

  typedef struct packed {
    logic [1:0]             status;
    logic [HANDLE_BITS-1:0] out_handle;
    logic [KEY_W-1:0]       out_key;
    logic [OCC_W-1:0]       occupancy;
  } rsp_t;

  // One queue entry
  typedef struct packed {
    logic [KEY_W-1:0]       key;
    logic [HANDLE_BITS-1:0] handle;
  } slot_t;

  // What every cell does this cycle
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD_AT,
    CELL_SHIFT_UP,
    CELL_SHIFT_DOWN
  } cell_op_t;

  // Broadcast control from the sequencer to the cell row
  typedef struct packed {
    cell_op_t               op;
    logic [IDX_W-1:0]       pos;
    logic [KEY_W-1:0]       key;
    logic [HANDLE_BITS-1:0] handle;
  } cell_ctl_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

endpackage

`default_nettype wire

### hw/rtl/kmq_cell.sv
`default_nettype none

module kmq_cell (
  input  logic               clk,
  input  kmq_pkg::cell_ctl_t ctl,
  input  logic [kmq_pkg::IDX_W-1:0] index,
  input  kmq_pkg::slot_t     prev,
  input  kmq_pkg::slot_t     next,
  output kmq_pkg::slot_t     slot,
  output logic               hit
);
  import kmq_pkg::*;

  // Entry storage: load in place, or take from a neighbor
  always_ff @(posedge clk) begin
    case (ctl.op)
      CELL_LOAD_AT: begin
        if (index == ctl.pos) begin
          slot.key    <= ctl.key;
          slot.handle <= ctl.handle;
        end
      end
      CELL_SHIFT_UP: begin
        if (index == '0) begin
          slot.key    <= ctl.key;
          slot.handle <= ctl.handle;
        end else begin
          slot <= prev;
        end
      end
      CELL_SHIFT_DOWN: begin
        if (index >= ctl.pos) begin
          slot <= next;
        end
      end
      default: begin
      end
    endcase
  end

  // Local key compare
  assign hit = (slot.key == ctl.key);

endmodule

`default_nettype wire

### hw/rtl/keyed_message_queue_core.sv
`default_nettype none

// Keyed message queue: an ordered queue of up to DEPTH (key, handle) entries
// held in a row of cells, head in cell 0. Push tail, push head, pop head and
// unused opcodes finish in the cycle the item is accepted, so one item per
// cycle while the result side keeps up. Remove and find walk the row one cell
// per cycle comparing the key. A removal closes the gap in the same cycle its
// result is loaded, as every cell from the match on takes its right neighbor.
// A new item is taken only after the previous one has finished and the result
// register has room.
module keyed_message_queue_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  kmq_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output kmq_pkg::rsp_t rsp
);
  import kmq_pkg::*;

  state_t           state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W-1:0] scan_pos, scan_pos_next;
  logic [2:0]       scan_op;
  logic [KEY_W-1:0] scan_key;

  cell_ctl_t        ctl;
  slot_t            slots [DEPTH];
  logic [DEPTH-1:0] hits;

  rsp_t             res;
  logic             res_load;
  logic             out_free;
  logic             accept;
  logic [IDX_W-1:0] scan_idx;

  // Row of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    slot_t prev_slot, next_slot;
    if (i == 0) begin : g_first
      assign prev_slot = '0;
    end else begin : g_mid_prev
      assign prev_slot = slots[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign next_slot = '0;
    end else begin : g_mid_next
      assign next_slot = slots[i+1];
    end
    kmq_cell u_cell (
      .clk   (clk),
      .ctl   (ctl),
      .index (IDX_W'(i)),
      .prev  (prev_slot),
      .next  (next_slot),
      .slot  (slots[i]),
      .hit   (hits[i])
    );
  end

  assign out_free  = !rsp_valid || !rsp_stall;
  assign req_stall = (state != ST_IDLE) || !out_free;
  assign accept    = req_valid && !req_stall;
  assign scan_idx  = scan_pos[IDX_W-1:0];

  // Sequencer: next state, cell commands and result
  always_comb begin
    state_next    = state;
    count_next    = count;
    scan_pos_next = scan_pos;
    ctl.op        = CELL_HOLD;
    ctl.pos       = '0;
    ctl.key       = req.search_key;
    ctl.handle    = req.record_handle;
    res_load      = 1'b0;
    res           = '0;
    res.status    = STAT_OK;

    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (req.opcode)
            OP_PUSH_TAIL: begin
              res_load = 1'b1;
              if (count == CNT_W'(DEPTH)) begin
                res.status = STAT_FULL;
              end else begin
                ctl.op     = CELL_LOAD_AT;
                ctl.pos    = count[IDX_W-1:0];
                count_next = count + 1'b1;
              end
            end
            OP_PUSH_HEAD: begin
              res_load = 1'b1;
              if (count == CNT_W'(DEPTH)) begin
                res.status = STAT_FULL;
              end else begin
                ctl.op     = CELL_SHIFT_UP;
                count_next = count + 1'b1;
              end
            end
            OP_POP_HEAD: begin
              res_load = 1'b1;
              if (count == '0) begin
                res.status = STAT_MISS;
              end else begin
                res.out_handle = slots[0].handle;
                res.out_key    = slots[0].key;
                ctl.op         = CELL_SHIFT_DOWN;
                ctl.pos        = '0;
                count_next     = count - 1'b1;
              end
            end
            OP_REMOVE, OP_FIND: begin
              scan_pos_next = '0;
              state_next    = ST_SCAN;
            end
            default: begin
              res_load = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        ctl.key = scan_key;
        if (scan_pos >= count) begin
          // walked past the tail: not found
          if (out_free) begin
            res_load   = 1'b1;
            res.status = STAT_MISS;
            state_next = ST_IDLE;
          end
        end else if (hits[scan_idx]) begin
          if (out_free) begin
            res_load       = 1'b1;
            res.out_handle = slots[scan_idx].handle;
            res.out_key    = slots[scan_idx].key;
            state_next     = ST_IDLE;
            if (scan_op == OP_REMOVE) begin
              ctl.op     = CELL_SHIFT_DOWN;
              ctl.pos    = scan_idx;
              count_next = count - 1'b1;
            end
          end
        end else begin
          scan_pos_next = scan_pos + 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    res.occupancy = OCC_W'(count_next);
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      scan_pos <= '0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      scan_pos <= scan_pos_next;
    end
  end

  // Search item hold
  always_ff @(posedge clk) begin
    if (accept) begin
      scan_op  <= req.opcode;
      scan_key <= req.search_key;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      rsp <= res;
    end
  end

endmodule

`default_nettype wire
